### src/bbd_pkg.sv
package bbd_pkg;

    localparam int LINE_DEPTH = 1024;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(390);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(300);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int N_EMIT = 4;
    localparam int EMIT_W = $clog2(N_EMIT);

    // bit 1 of an emit code: pixel of the current (last) row; bit 0: last column
    localparam logic [EMIT_W-1:0] EMIT_PREV_INNER = 2'd0;
    localparam logic [EMIT_W-1:0] EMIT_PREV_EDGE  = 2'd1;
    localparam logic [EMIT_W-1:0] EMIT_LAST_INNER = 2'd2;
    localparam logic [EMIT_W-1:0] EMIT_LAST_EDGE  = 2'd3;

    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic last_col;
        logic last_row;
        logic top_mirror;
        logic left_mirror;
        logic row_odd;
        logic col_odd;
    } t_flags;

    typedef struct packed {
        t_win   win;
        t_flags flags;
    } t_job;

    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
    } t_geom;

endpackage

### src/bbd_front.sv
module bbd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bbd_pkg::PIX_W-1:0]   i_raw_pixel,
    input  bbd_pkg::t_geom              i_geom,
    input  logic [bbd_pkg::Q_CNT_W-1:0] i_q_count,
    output logic                        o_push,
    output bbd_pkg::t_job               o_job
);
    import bbd_pkg::*;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [PIX_W-1:0] r_line_a [LINE_DEPTH];
    logic [PIX_W-1:0] r_line_b [LINE_DEPTH];
    logic [PIX_W-1:0] r_rd_a;
    logic [PIX_W-1:0] r_rd_b;

    logic             r_s1_valid;
    logic             r_s1_push;
    logic [COL_W-1:0] r_s1_addr;
    logic [PIX_W-1:0] r_s1_px;
    t_flags           r_s1_flags;

    t_win   r_win;
    t_win   n_win;
    logic   acc;
    logic   last_c;
    logic   last_r;
    t_flags flags;

    assign o_ready = (i_q_count + Q_CNT_W'(r_s1_valid)) < Q_CNT_W'(Q_DEPTH);
    assign acc     = i_valid && o_ready;
    assign last_c  = r_col >= i_geom.last_col;
    assign last_r  = r_row >= i_geom.last_row;

    always_comb begin
        flags.last_col    = last_c;
        flags.last_row    = last_r;
        flags.top_mirror  = r_row == ROW_W'(1);
        flags.left_mirror = r_col == COL_W'(1);
        flags.row_odd     = r_row[0];
        flags.col_odd     = r_col[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (last_c) begin
                r_col <= '0;
                r_row <= last_r ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_line_a[r_col] <= i_raw_pixel;
            r_rd_a          <= r_line_a[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_line_b[r_s1_addr] <= r_rd_a;
        end
        if (acc) begin
            r_rd_b <= r_line_b[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
        if (acc) begin
            r_s1_push  <= (r_row != '0) && (r_col != '0);
            r_s1_addr  <= r_col;
            r_s1_px    <= i_raw_pixel;
            r_s1_flags <= flags;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = r_rd_b;
        n_win[1][2] = r_rd_a;
        n_win[2][2] = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_push      = r_s1_valid && r_s1_push;
    assign o_job.win   = n_win;
    assign o_job.flags = r_s1_flags;

endmodule

### src/bbd_queue.sv
module bbd_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  bbd_pkg::t_job               i_job,
    input  logic                        i_pop,
    output bbd_pkg::t_job               o_head,
    output logic [bbd_pkg::Q_CNT_W-1:0] o_count
);
    import bbd_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

### src/bbd_back.sv
module bbd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bbd_pkg::t_job             i_head,
    input  logic                      i_head_valid,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [bbd_pkg::PIX_W-1:0] o_red_value,
    output logic [bbd_pkg::PIX_W-1:0] o_green_value,
    output logic [bbd_pkg::PIX_W-1:0] o_blue_value,
    output logic                      o_last_of_run,
    output logic                      o_frame_end
);
    import bbd_pkg::*;

    localparam logic [1:0] SITE_GR = 2'b00;
    localparam logic [1:0] SITE_R  = 2'b01;
    localparam logic [1:0] SITE_B  = 2'b10;
    localparam logic [1:0] SITE_GB = 2'b11;

    logic [N_EMIT-1:0] r_done;
    logic              r_valid;
    logic [PIX_W-1:0]  r_red;
    logic [PIX_W-1:0]  r_green;
    logic [PIX_W-1:0]  r_blue;
    logic              r_last;
    logic              r_fend;

    logic [N_EMIT-1:0] mask;
    logic [N_EMIT-1:0] pend;
    logic [N_EMIT-1:0] sel_oh;
    logic [N_EMIT-1:0] remaining;
    logic [EMIT_W-1:0] em;
    logic [1:0]        rt, rm, rb, cl, cm, cr;
    logic              odd_r, odd_c;
    logic [PIX_W-1:0]  ctr;
    logic [PIX_W:0]    hor_s, ver_s;
    logic [PIX_W+1:0]  dia_s, crs_s;
    logic [PIX_W-1:0]  n_red, n_green, n_blue;
    logic              advance;
    t_win              w;

    assign w    = i_head.win;
    assign mask = {i_head.flags.last_row && i_head.flags.last_col,
                   i_head.flags.last_row, i_head.flags.last_col, 1'b1};
    assign pend = mask & ~r_done;

    always_comb begin
        if (pend[0]) begin
            em = EMIT_PREV_INNER;
        end else if (pend[1]) begin
            em = EMIT_PREV_EDGE;
        end else if (pend[2]) begin
            em = EMIT_LAST_INNER;
        end else begin
            em = EMIT_LAST_EDGE;
        end
        sel_oh    = N_EMIT'(1) << em;
        remaining = pend & ~sel_oh;
    end

    always_comb begin
        if (em == EMIT_PREV_INNER || em == EMIT_PREV_EDGE) begin
            rt    = i_head.flags.top_mirror ? 2'd2 : 2'd0;
            rm    = 2'd1;
            rb    = 2'd2;
            odd_r = !i_head.flags.row_odd;
        end else begin
            rt    = 2'd1;
            rm    = 2'd2;
            rb    = 2'd1;
            odd_r = i_head.flags.row_odd;
        end
        if (em == EMIT_PREV_INNER || em == EMIT_LAST_INNER) begin
            cl    = i_head.flags.left_mirror ? 2'd2 : 2'd0;
            cm    = 2'd1;
            cr    = 2'd2;
            odd_c = !i_head.flags.col_odd;
        end else begin
            cl    = 2'd1;
            cm    = 2'd2;
            cr    = 2'd1;
            odd_c = i_head.flags.col_odd;
        end
    end

    always_comb begin
        ctr   = w[rm][cm];
        hor_s = {1'b0, w[rm][cl]} + {1'b0, w[rm][cr]};
        ver_s = {1'b0, w[rt][cm]} + {1'b0, w[rb][cm]};
        dia_s = {2'b0, w[rt][cl]} + {2'b0, w[rt][cr]}
              + {2'b0, w[rb][cl]} + {2'b0, w[rb][cr]};
        crs_s = {1'b0, ver_s} + {1'b0, hor_s};
        case ({odd_r, odd_c})
            SITE_R: begin
                n_red   = ctr;
                n_green = crs_s[PIX_W+1:2];
                n_blue  = dia_s[PIX_W+1:2];
            end
            SITE_B: begin
                n_red   = dia_s[PIX_W+1:2];
                n_green = crs_s[PIX_W+1:2];
                n_blue  = ctr;
            end
            SITE_GB: begin
                n_red   = ver_s[PIX_W:1];
                n_green = ctr;
                n_blue  = hor_s[PIX_W:1];
            end
            SITE_GR: begin
                n_red   = hor_s[PIX_W:1];
                n_green = ctr;
                n_blue  = ver_s[PIX_W:1];
            end
            default: begin
                n_red   = ctr;
                n_green = ctr;
                n_blue  = ctr;
            end
        endcase
    end

    assign advance = i_head_valid && (!r_valid || i_ready);
    assign o_pop   = advance && (remaining == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_done  <= (remaining == '0) ? '0 : (r_done | sel_oh);
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_last  <= remaining == '0;
            r_fend  <= em == EMIT_LAST_EDGE;
        end
    end

    assign o_valid       = r_valid;
    assign o_red_value   = r_red;
    assign o_green_value = r_green;
    assign o_blue_value  = r_blue;
    assign o_last_of_run = r_last;
    assign o_frame_end   = r_fend;

endmodule

### src/bayer_bilinear_demosaic_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_raw_pixel
// output    out        o_valid / i_ready  o_red_value o_green_value o_blue_value
//                                         o_last_of_run o_frame_end
// config    in         APB psel/penable   paddr pwdata prdata (width at 0, height at 4)
//
// One raw sample accepted per cycle while o_ready is high; each gives 0 to 4 RGB results,
// sent one per cycle unless stalled, by the single interpolation unit in the back end.
// First result of a transaction: front stage register, then job queue, then output register.
// A four-deep job queue absorbs the bursts at the last column and row; o_ready
// drops once the queue and the stage feeding it hold four jobs.
// Output stalls hold the output register.
// Reset clears counters, window and queue, and sets 390 x 300; line stores are not cleared.
module bayer_bilinear_demosaic_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bbd_pkg::PIX_W-1:0]    i_raw_pixel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bbd_pkg::PIX_W-1:0]    o_red_value,
    output logic [bbd_pkg::PIX_W-1:0]    o_green_value,
    output logic [bbd_pkg::PIX_W-1:0]    o_blue_value,
    output logic                         o_last_of_run,
    output logic                         o_frame_end,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbd_pkg::APB_AW-1:0]   paddr,
    input  logic [bbd_pkg::APB_DW-1:0]   pwdata,
    output logic [bbd_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import bbd_pkg::*;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  w_m1;
    logic [HEIGHT_W-1:0] h_m1;
    t_geom               geom;
    logic                reg_sel;
    logic                q_push;
    logic                q_pop;
    t_job                q_in;
    t_job                q_head;
    logic [Q_CNT_W-1:0]  q_count;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_WIDTH:  r_width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_height <= pwdata[HEIGHT_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    // clamp geometry to the supported range
    always_comb begin
        w_m1 = r_width - WIDTH_W'(1);
        h_m1 = r_height - HEIGHT_W'(1);
        if (r_width < WIDTH_W'(2)) begin
            geom.last_col = COL_W'(1);
        end else if (r_width > WIDTH_W'(LINE_DEPTH)) begin
            geom.last_col = COL_W'(LINE_DEPTH - 1);
        end else begin
            geom.last_col = w_m1[COL_W-1:0];
        end
        if (r_height < HEIGHT_W'(2)) begin
            geom.last_row = ROW_W'(1);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            geom.last_row = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            geom.last_row = h_m1[ROW_W-1:0];
        end
    end

    bbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_raw_pixel (i_raw_pixel),
        .i_geom      (geom),
        .i_q_count   (q_count),
        .o_push      (q_push),
        .o_job       (q_in)
    );

    bbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_count (q_count)
    );

    bbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (q_head),
        .i_head_valid  (q_count != '0),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red_value   (o_red_value),
        .o_green_value (o_green_value),
        .o_blue_value  (o_blue_value),
        .o_last_of_run (o_last_of_run),
        .o_frame_end   (o_frame_end)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("job queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count < Q_CNT_W'(Q_DEPTH)) || q_pop)
        else $error("job pushed into a full queue");

    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_last_of_run)
        else $error("frame end not on the last result of its transaction");

endmodule

### verif/demosaic_checker.sv
`timescale 1ns / 100ps

module demosaic_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_raw_valid,
    input  logic                        i_raw_ready,
    input  logic [bbd_pkg::PIX_W-1:0]   i_raw_pixel,
    input  logic                        i_rgb_valid,
    input  logic                        i_rgb_ready,
    input  logic [bbd_pkg::PIX_W-1:0]   i_red_value,
    input  logic [bbd_pkg::PIX_W-1:0]   i_green_value,
    input  logic [bbd_pkg::PIX_W-1:0]   i_blue_value,
    input  logic                        i_last_of_run,
    input  logic                        i_frame_end,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [bbd_pkg::APB_AW-1:0]  i_paddr,
    input  logic [bbd_pkg::APB_DW-1:0]  i_pwdata,
    input  logic [bbd_pkg::APB_DW-1:0]  i_prdata,
    input  logic                        i_pready,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_errors
);
    import bbd_pkg::*;

    localparam logic [APB_AW-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last_of_run;
        logic             frame_end;
    } t_rgb_pixel;

    // colour at a site, indexed by {row odd, column odd}
    typedef enum logic [1:0] {
        SITE_GREEN_RED_ROW  = 2'b00,
        SITE_RED            = 2'b01,
        SITE_BLUE           = 2'b10,
        SITE_GREEN_BLUE_ROW = 2'b11
    } t_bayer_site;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [PIX_W-1:0]    row_above     [LINE_DEPTH];
    logic [PIX_W-1:0]    row_two_above [LINE_DEPTH];
    logic [PIX_W-1:0]    win [3][3];
    int unsigned         row_pos;
    int unsigned         col_pos;
    t_rgb_pixel          expected_rgb [$];
    int                  checked;
    int                  errors;

    function automatic t_rgb_pixel interpolate(int rt, int rm, int rb, int cl, int cm, int cr,
                                               int unsigned row, int unsigned col, logic fend);
        int unsigned ctr;
        int unsigned hor;
        int unsigned ver;
        int unsigned dia;
        int unsigned crs;
        t_bayer_site site;
        t_rgb_pixel  px;
        ctr = int'(win[rm][cm]);
        hor = (int'(win[rm][cl]) + int'(win[rm][cr])) / 2;
        ver = (int'(win[rt][cm]) + int'(win[rb][cm])) / 2;
        dia = (int'(win[rt][cl]) + int'(win[rt][cr]) + int'(win[rb][cl])
               + int'(win[rb][cr])) / 4;
        crs = (int'(win[rt][cm]) + int'(win[rb][cm]) + int'(win[rm][cl])
               + int'(win[rm][cr])) / 4;
        site = t_bayer_site'({row[0], col[0]});
        px.last_of_run = 1'b0;
        px.frame_end   = fend;
        case (site)
            SITE_RED: begin
                px.red = PIX_W'(ctr); px.green = PIX_W'(crs); px.blue = PIX_W'(dia);
            end
            SITE_BLUE: begin
                px.red = PIX_W'(dia); px.green = PIX_W'(crs); px.blue = PIX_W'(ctr);
            end
            SITE_GREEN_BLUE_ROW: begin
                px.red = PIX_W'(ver); px.green = PIX_W'(ctr); px.blue = PIX_W'(hor);
            end
            default: begin
                px.red = PIX_W'(hor); px.green = PIX_W'(ctr); px.blue = PIX_W'(ver);
            end
        endcase
        return px;
    endfunction

    // one raw sample in: slide the window, update line stores, queue the pixels it completes
    function void absorb_raw(logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        bit          lastc;
        bit          lastr;
        t_rgb_pixel  res [4];
        int          n;
        int          rt;
        int          cl;
        int          i;
        w = 32'(width_reg);
        if (w < 2) w = 2;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = 32'(height_reg);
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        r = row_pos;
        c = col_pos;
        idx = (c < LINE_DEPTH) ? c : LINE_DEPTH - 1;
        lastc = (c >= w - 1);
        lastr = (r >= h - 1);
        for (i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = row_two_above[idx];
        win[1][2] = row_above[idx];
        win[2][2] = px;
        row_two_above[idx] = row_above[idx];
        row_above[idx] = px;

        n = 0;
        rt = (r == 1) ? 2 : 0;
        cl = (c == 1) ? 2 : 0;
        if (r >= 1) begin
            if (c >= 1) begin
                res[n] = interpolate(rt, 1, 2, cl, 1, 2, r - 1, c - 1, 1'b0);
                n++;
            end
            if (lastc) begin
                res[n] = interpolate(rt, 1, 2, 1, 2, 1, r - 1, c, 1'b0);
                n++;
            end
            if (lastr && c >= 1) begin
                res[n] = interpolate(1, 2, 1, cl, 1, 2, r, c - 1, 1'b0);
                n++;
            end
            if (lastr && lastc) begin
                res[n] = interpolate(1, 2, 1, 1, 2, 1, r, c, 1'b1);
                n++;
            end
        end
        if (n > 0) res[n-1].last_of_run = 1'b1;
        for (i = 0; i < n; i++) expected_rgb.push_back(res[i]);

        if (lastc) begin
            col_pos = 0;
            row_pos = lastr ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rgb_pixel want;
        int i;
        int j;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            row_pos = 0;
            col_pos = 0;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++) win[i][j] = '0;
            for (i = 0; i < LINE_DEPTH; i++) begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
            end
            expected_rgb.delete();
            checked = 0;
            errors  = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == WIDTH_ADDR) width_reg = i_pwdata[WIDTH_W-1:0];
                    if (i_paddr == HEIGHT_ADDR) height_reg = i_pwdata[HEIGHT_W-1:0];
                end else begin
                    if (i_paddr == WIDTH_ADDR)
                        compare_field("image_width readback", 32'(width_reg), i_prdata);
                    if (i_paddr == HEIGHT_ADDR)
                        compare_field("image_height readback", 32'(height_reg), i_prdata);
                end
            end
            if (i_raw_valid && i_raw_ready) absorb_raw(i_raw_pixel);
            if (i_rgb_valid && i_rgb_ready) begin
                if (expected_rgb.size() == 0) begin
                    $error("RGB transaction with no pixel expected");
                    errors++;
                end else begin
                    want = expected_rgb.pop_front();
                    compare_field("red_value", 32'(want.red), 32'(i_red_value));
                    compare_field("green_value", 32'(want.green), 32'(i_green_value));
                    compare_field("blue_value", 32'(want.blue), 32'(i_blue_value));
                    compare_field("last_of_run", 32'(want.last_of_run),
                                  32'(i_last_of_run));
                    compare_field("frame_end", 32'(want.frame_end), 32'(i_frame_end));
                    checked++;
                end
            end
        end
        o_pending <= expected_rgb.size();
        o_checked <= checked;
        o_errors  <= errors;
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bbd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 360;
    // at most ~1k samples, each under maximal stalls, several times over
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    localparam logic [APB_AW-1:0] WIDTH_ADDR  = {REG_WIDTH, 2'b00};
    localparam logic [APB_AW-1:0] HEIGHT_ADDR = {REG_HEIGHT, 2'b00};

    typedef enum {PIX_FULL, PIX_CORNER} t_pix_mode;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [PIX_W-1:0]  i_raw_pixel = '0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [PIX_W-1:0]  o_red_value;
    logic [PIX_W-1:0]  o_green_value;
    logic [PIX_W-1:0]  o_blue_value;
    logic              o_last_of_run;
    logic              o_frame_end;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int          pending;
    int          compared;
    int          mismatches;
    int unsigned cycle_count   = 0;
    int unsigned raw_sent      = 0;
    int unsigned geometry_sets = 0;
    bit          steady_sender = 1'b0;
    logic        hold_request  = 1'b0;

    bayer_bilinear_demosaic_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_raw_pixel   (i_raw_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red_value   (o_red_value),
        .o_green_value (o_green_value),
        .o_blue_value  (o_blue_value),
        .o_last_of_run (o_last_of_run),
        .o_frame_end   (o_frame_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    demosaic_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_raw_valid   (i_valid),
        .i_raw_ready   (o_ready),
        .i_raw_pixel   (i_raw_pixel),
        .i_rgb_valid   (o_valid),
        .i_rgb_ready   (i_ready),
        .i_red_value   (o_red_value),
        .i_green_value (o_green_value),
        .i_blue_value  (o_blue_value),
        .i_last_of_run (o_last_of_run),
        .i_frame_end   (o_frame_end),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_pending     (pending),
        .o_checked     (compared),
        .o_errors      (mismatches)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 31);
        if (p < 12) return 0;
        if (p < 29) return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned frame_pixels(int unsigned w, int unsigned h);
        if (w < 2) w = 2;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (h < 2) h = 2;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return w * h;
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(t_pix_mode mode);
        if (mode == PIX_FULL && $urandom_range(0, 7) != 0) return PIX_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return PIX_W'(8'hAA);
            default: return PIX_W'(8'h55);
        endcase
    endfunction

    task automatic send_raw(input logic [PIX_W-1:0] px);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_raw_pixel <= px;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        raw_sent++;
    endtask

    task automatic stream(input int unsigned count, input t_pix_mode mode);
        for (int unsigned k = 0; k < count; k++) send_raw(next_pixel(mode));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        drain();
        apb_access(1'b1, WIDTH_ADDR, APB_DW'(w));
        apb_access(1'b1, HEIGHT_ADDR, APB_DW'(h));
        apb_access(1'b0, WIDTH_ADDR, '0);
        apb_access(1'b0, HEIGHT_ADDR, '0);
        geometry_sets++;
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int  run;
        int  gap;
        bit  hold_done;
        hold_done = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 12);
                i_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int unsigned random_items;
        int          phase;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, clamped sizes, odd width
        set_geometry(2, 2);
        stream(4, PIX_CORNER);
        set_geometry(0, 0);
        stream(4, PIX_CORNER);
        set_geometry(3, 3);
        stream(9, PIX_FULL);
        set_geometry(1, 3);
        stream(6, PIX_CORNER);

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS || phase <= 2) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);
                1:       w = $urandom_range(11, 40);
                default: w = $urandom_range(2, 10);
            endcase
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            count = $urandom_range(1, 2);
            steady_sender = ($urandom_range(0, 3) == 0);
            if (phase == 2) begin
                w = 8;
                h = 6;
                count = 6;
                steady_sender = 1'b1;
            end
            set_geometry(w, h);
            if (phase == 2) hold_request <= 1'b1;
            count = count * frame_pixels(w, h);
            stream(count, PIX_FULL);
            random_items += count;
            phase++;
        end
        steady_sender = 1'b0;

        // shrink mid-frame: column already past the new last one, row becomes the last
        set_geometry(8, 6);
        stream(14, PIX_FULL);
        set_geometry(4, 3);
        stream(5, PIX_FULL);

        // oversized and full-width geometry, closed early by a mid-frame shrink
        set_geometry(LINE_DEPTH, 2);
        stream(12, PIX_FULL);
        set_geometry(4, 2);
        stream(5, PIX_FULL);
        set_geometry(2047, 2);
        stream(12, PIX_FULL);
        set_geometry(4, 2);
        stream(5, PIX_FULL);
        set_geometry(2, 8191);
        stream(6, PIX_FULL);
        set_geometry(2, 4);
        stream(2, PIX_FULL);

        drain();
        $display("covered %0d raw samples over %0d frame geometries, incl. mid-frame shrink",
                 raw_sent, geometry_sets);
        $display("%0d RGB pixels compared, %0d mismatches", compared, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
src/bbd_pkg.sv
src/bbd_front.sv
src/bbd_queue.sv
src/bbd_back.sv
src/bayer_bilinear_demosaic_unit.sv
verif/demosaic_checker.sv
verif/testbench.sv
